### rtl/core/variable_length_bit_packer_assert.svh
// Assertion macros for the variable-length bit packer.
`ifndef VARIABLE_LENGTH_BIT_PACKER_ASSERT_SVH
`define VARIABLE_LENGTH_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while in reset.
`define VLBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlbp assertion failed");

// Next-cycle implication, sampled on clk, ignored while in reset.
`define VLBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlbp assertion failed");

`endif

### rtl/core/vlbp_pkg.sv
// Package for the variable-length bit packer: constants, result struct, helpers.
package vlbp_pkg;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned ValBits   = 64;
  localparam int unsigned LenBits   = 7;
  localparam int unsigned PendBits  = ByteBits - 1;
  localparam int unsigned CntBits   = 3;
  localparam int unsigned NbBits    = 4;
  localparam int unsigned WinBits   = ValBits + ByteBits;

  localparam logic [LenBits-1:0] MaxLen = 7'd64;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [ValBits-1:0]  bytes;     // completed bytes, first in [63:56]
    logic [NbBits-1:0]   nbytes;    // 0..8
    logic [PendBits-1:0] pend_bits;
    logic [CntBits-1:0]  pend_cnt;
  } pack_res_t;

  function automatic logic [ValBits-1:0] bit_rev(input logic [ValBits-1:0] v);
    logic [ValBits-1:0] r;
    for (int i = 0; i < ValBits; i++) begin
      r[i] = v[ValBits-1-i];
    end
    return r;
  endfunction

endpackage

### rtl/core/vlbp_pack.sv
// Single-pass packing logic: lines up pending and new bits, splits off whole bytes.
module vlbp_pack (
  input  logic                             opcode,
  input  logic [vlbp_pkg::ValBits-1:0]     value,
  input  logic [vlbp_pkg::LenBits-1:0]     length,
  input  logic [vlbp_pkg::PendBits-1:0]    pend_bits,
  input  logic [vlbp_pkg::CntBits-1:0]     pend_cnt,
  output vlbp_pkg::pack_res_t              res
);
  import vlbp_pkg::*;

  logic [LenBits-1:0]  eff_len;
  logic [ValBits-1:0]  rev_m;
  logic [PendBits-1:0] pend_al;
  logic [WinBits-1:0]  win;
  logic [WinBits-1:0]  tail;
  logic [LenBits-1:0]  total;
  logic [CntBits-1:0]  rem;
  logic [NbBits-1:0]   nb;
  logic [ByteBits-1:0] tail_byte;

  always_comb begin
    // Flush behaves as a zero-length write, then emits any pending bits as one zero-padded byte and clears them.
    if (opcode == OP_FLUSH) begin
      eff_len = '0;
    end else if (length > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = length;
    end

    // Value bit 0 goes first, so reverse and keep the top eff_len bits.
    rev_m   = bit_rev(value) & ~({ValBits{1'b1}} >> eff_len);
    pend_al = pend_bits << (CntBits'(PendBits) - pend_cnt);
    win     = {pend_al, {(WinBits-PendBits){1'b0}}}
            | ({rev_m, {ByteBits{1'b0}}} >> pend_cnt);

    total = {{(LenBits-CntBits){1'b0}}, pend_cnt} + eff_len;
    rem   = total[CntBits-1:0];

    tail      = win << ({total[LenBits-1:CntBits], 3'b000});
    tail_byte = tail[WinBits-1 -: ByteBits];

    res.bytes = win[WinBits-1 -: ValBits];
    if (opcode == OP_FLUSH) begin
      nb            = (pend_cnt != '0) ? NbBits'(1) : '0;
      res.pend_bits = '0;
      res.pend_cnt  = '0;
    end else begin
      nb            = total[LenBits-1:CntBits];
      res.pend_bits = PendBits'(tail_byte >> (NbBits'(ByteBits) - {1'b0, rem}));
      res.pend_cnt  = rem;
    end
    res.nbytes = nb;
  end

endmodule

### rtl/core/variable_length_bit_packer.sv
// Top level of the variable-length bit packer: input register, packing, byte output buffer.
//
// Packs write requests (up to 64 value bits, bit 0 first) into bytes filled
// from bit 7 down; a flush request pads pending bits with zeros and emits one
// byte, or nothing if no bits are pending. The last byte of each request has
// out_last_of_item set. Requests pass through an input register, are packed
// combinationally and land in an eight-byte output buffer that drains one byte
// per cycle while out_stall is low. A request that yields n bytes (up to 8 for
// a 64-bit write) holds the output buffer until all n have been taken. A
// request that yields no byte never waits for the output. The next request is
// taken while the buffer still drains, and moves into the buffer as its last
// byte leaves. An accepted request is registered in the input register and
// then in the output buffer, which drives its first byte.
module variable_length_bit_packer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [vlbp_pkg::ValBits-1:0]  in_value,
  input  logic [vlbp_pkg::LenBits-1:0]  in_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vlbp_pkg::ByteBits-1:0] out_byte,
  output logic                          out_last_of_item
);
  import vlbp_pkg::*;

  `include "variable_length_bit_packer_assert.svh"

  // input register
  logic                in_vld_r;
  logic                op_r;
  logic [ValBits-1:0]  val_r;
  logic [LenBits-1:0]  len_r;

  // packing state
  logic [PendBits-1:0] pend_bits_r;
  logic [CntBits-1:0]  pend_cnt_r;

  // output buffer: bytes left to send, next one in the top byte
  logic [ValBits-1:0]  buf_data_r;
  logic [NbBits-1:0]   buf_left_r;

  pack_res_t res;
  logic      in_accept;
  logic      out_take;
  logic      buf_free;
  logic      s1_go;

  vlbp_pack u_pack (
    .opcode    (op_r),
    .value     (val_r),
    .length    (len_r),
    .pend_bits (pend_bits_r),
    .pend_cnt  (pend_cnt_r),
    .res       (res)
  );

  assign out_valid        = (buf_left_r != '0);
  assign out_byte         = buf_data_r[ValBits-1 -: ByteBits];
  assign out_last_of_item = (buf_left_r == NbBits'(1));
  assign out_take         = out_valid && !out_stall;

  // Buffer can take a new request when empty or when its last byte leaves now.
  assign buf_free  = (buf_left_r == '0) || (out_last_of_item && !out_stall);
  // A request with no bytes only updates the state and never waits.
  assign s1_go     = in_vld_r && ((res.nbytes == '0) || buf_free);
  assign in_stall  = in_vld_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (s1_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= in_opcode;
      val_r <= in_value;
      len_r <= in_length;
    end
  end

  // Pending bits commit as the request leaves the input register, in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (s1_go) begin
      pend_bits_r <= res.pend_bits;
      pend_cnt_r  <= res.pend_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_left_r <= '0;
    end else if (s1_go && (res.nbytes != '0)) begin
      buf_left_r <= res.nbytes;
    end else if (out_take) begin
      buf_left_r <= buf_left_r - NbBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (res.nbytes != '0)) begin
      buf_data_r <= res.bytes;
    end else if (out_take) begin
      buf_data_r <= buf_data_r << ByteBits;
    end
  end

  // A taken byte that is not the last of its request is followed by another.
  `VLBP_ASSERT_NEXT(a_more_bytes, out_take && !out_last_of_item, out_valid)
  // Unused pending bits stay zero; an empty accumulator holds no bits.
  `VLBP_ASSERT_NOW(a_pend_clean, pend_cnt_r == '0, pend_bits_r == '0)
  // A request that yields bytes shows them on the next cycle.
  `VLBP_ASSERT_NEXT(a_buf_loaded, s1_go && (res.nbytes != '0), out_valid)
  // Buffer never holds more than eight bytes.
  `VLBP_ASSERT_NOW(a_buf_bound, 1'b1, buf_left_r <= NbBits'(ByteBits))

endmodule

### test/tb_top.sv
// Self-checking testbench for the variable-length bit packer: queued requests, MSB-first byte check.
`timescale 1ns / 100ps

module tb_top;
  import vlbp_pkg::*;

  // Run limits. The slowest correct run is roughly 235 requests of eight bytes
  // each, every byte held off by a long stall plus a sender gap; CycleLimit is
  // set several times above the length of such a run.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;   // wait after the last byte before ending the run
  localparam int unsigned RandomReqs  = 210;

  // One input request as it goes onto the ports.
  typedef struct {
    opcode_t                 op;
    logic [ValBits-1:0]      value;
    logic [LenBits-1:0]      length;
  } pack_req_t;

  // One expected output byte.
  typedef struct {
    logic [ByteBits-1:0] data;
    logic                last;
  } packed_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_opcode = 1'b0;
  logic [ValBits-1:0]  in_value = '0;
  logic [LenBits-1:0]  in_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ByteBits-1:0] out_byte;
  logic                out_last_of_item;

  variable_length_bit_packer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_length        (in_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be driven, and bytes the packer still owes us.
  pack_req_t    req_queue[$];
  packed_byte_t byte_fifo[$];

  // Our own copy of the packer state: bits not yet emitted, newest in bit 0.
  logic [PendBits-1:0] model_pend_bits = '0;
  logic [CntBits-1:0]  model_pend_cnt  = '0;

  int unsigned cycle_cnt = 0;
  int unsigned err_cnt   = 0;
  int unsigned reqs_done = 0;
  int unsigned flush_cnt = 0;
  int unsigned bytes_ok  = 0;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  task automatic report_mismatch(input string what, input logic [ByteBits-1:0] got,
                                 input logic [ByteBits-1:0] want);
    err_cnt++;
    $display("[%0t] MISMATCH %s: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
  endtask

  // Pack one accepted request into the model state and queue the bytes that
  // it completes. Bits beyond the length are ignored; lengths above 64 clamp.
  task automatic pack_request(input pack_req_t r);
    logic [ByteBits-1:0] acc;
    logic [3:0]          cnt;
    logic [ByteBits-1:0] padded;
    int unsigned         len;
    int unsigned         total;
    int unsigned         made;
    acc  = {1'b0, model_pend_bits};
    cnt  = {1'b0, model_pend_cnt};
    made = 0;
    if (r.op == OP_FLUSH) begin
      flush_cnt++;
      // nothing pending means nothing to pad, so no byte at all
      if (cnt != 0) begin
        padded = acc << (ByteBits - 32'(cnt));
        byte_fifo.push_back('{data: padded, last: 1'b1});
      end
      model_pend_bits = '0;
      model_pend_cnt  = '0;
    end else begin
      len   = 32'((r.length > MaxLen) ? MaxLen : r.length);
      total = (32'(cnt) + len) / ByteBits;
      for (int i = 0; i < len; i++) begin
        acc = {acc[ByteBits-2:0], r.value[i]};
        cnt++;
        if (32'(cnt) == ByteBits) begin
          // last marker only on the final byte this request makes
          byte_fifo.push_back('{data: acc, last: (made == total - 1)});
          made++;
          acc = '0;
          cnt = '0;
        end
      end
      model_pend_bits = acc[PendBits-1:0];
      model_pend_cnt  = cnt[CntBits-1:0];
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of requests of random length with random gaps in between.
  // A stalled request is held as it is; the next one is popped only once the
  // current one has gone.
  // --------------------------------------------------------------------------
  pack_req_t   cur_req;
  int unsigned burst_left = 4;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_opcode <= 1'b0;
      in_value  <= '0;
      in_length <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        pack_request(cur_req);
        reqs_done++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          in_valid  <= 1'b1;
          in_opcode <= cur_req.op;
          in_value  <= cur_req.value;
          in_length <= cur_req.length;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            // a quarter of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure. The mode is re-drawn at random when its countdown ends:
  // no stall at all, light random, heavy random, and a fixed 3-in-7 pattern.
  // --------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 200;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(150, 400);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= ((cycle_cnt % 7) < 3);
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted byte is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (byte_fifo.size() == 0) begin
        report_mismatch("byte with nothing outstanding", out_byte, 8'h00);
      end else begin
        want = byte_fifo.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", out_byte, want.data);
        else if (out_last_of_item !== want.last)
          report_mismatch("out_last_of_item", {7'd0, out_last_of_item}, {7'd0, want.last});
        else
          bytes_ok++;
      end
    end
  end

  task automatic queue_request(input opcode_t op, input logic [ValBits-1:0] value,
                               input logic [LenBits-1:0] length);
    req_queue.push_back('{op: op, value: value, length: length});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned pick;
    logic [ValBits-1:0]  val;
    logic [LenBits-1:0]  len;

    // Directed: flush on an empty stream, zero length, single bits, exact
    // byte boundaries, padding, full and clamped lengths, ignored high bits.
    queue_request(OP_FLUSH, '1, 7'h7F);                 // empty flush, junk fields
    queue_request(OP_WRITE, '1, 7'd0);                  // zero length
    queue_request(OP_WRITE, 64'h1, 7'd1);
    queue_request(OP_WRITE, 64'h55, 7'd7);              // completes a byte
    queue_request(OP_WRITE, 64'hA5, 7'd8);
    queue_request(OP_WRITE, 64'h5, 7'd3);
    queue_request(OP_WRITE, '1, 7'd0);                  // zero length with bits pending
    queue_request(OP_FLUSH, '0, 7'd0);                  // padded byte
    queue_request(OP_FLUSH, '0, 7'd0);                  // nothing left
    queue_request(OP_WRITE, '1, 7'd64);
    queue_request(OP_WRITE, '0, 7'd64);
    queue_request(OP_WRITE, 64'h0123_4567_89AB_CDEF, 7'd65);   // clamps to 64
    queue_request(OP_WRITE, 64'hAAAA_5555_AAAA_5555, 7'h7F);   // clamps to 64
    queue_request(OP_WRITE, 64'h13, 7'd5);
    queue_request(OP_FLUSH, '1, 7'h7F);
    queue_request(OP_WRITE, 64'hFEDC_BA98_7654_3210, 7'd63);
    queue_request(OP_WRITE, 64'h1, 7'd1);
    queue_request(OP_WRITE, '1, 7'd4);                  // high bits must be ignored
    queue_request(OP_WRITE, 64'h0, 7'd4);
    queue_request(OP_WRITE, 64'h6, 7'd3);
    queue_request(OP_WRITE, 64'hC3C3_3C3C_F0F0_0F0F, 7'd64);  // eight bytes, three left
    queue_request(OP_FLUSH, '0, 7'd0);
    queue_request(OP_WRITE, 64'h2, 7'd2);               // packing resumes after flush
    queue_request(OP_WRITE, 64'h7F, 7'd6);

    // Random: mostly writes of assorted lengths with full random values,
    // a sprinkling of flushes and out-of-range lengths.
    for (int n = 0; n < RandomReqs; n++) begin
      val  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        queue_request(OP_FLUSH, val, LenBits'($urandom));
      end else begin
        if (pick < 50)      len = LenBits'($urandom_range(1, 16));
        else if (pick < 78) len = LenBits'($urandom_range(17, 63));
        else if (pick < 88) len = 7'd64;
        else if (pick < 93) len = 7'd0;
        else                len = LenBits'($urandom_range(65, 127));
        queue_request(OP_WRITE, val, len);
      end
    end
    queue_request(OP_FLUSH, '0, 7'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // wait until every request has been taken and every byte has come out
    while (req_queue.size() != 0 || in_valid || byte_fifo.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d requests (%0d flushes), %0d bytes matched, %0d mismatches.",
             reqs_done, flush_cnt, bytes_ok, err_cnt);
    $display("Sender bursts and four receiver stall modes were exercised over %0d cycles.",
             cycle_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost byte ends here.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles, %0d bytes still outstanding.",
             cycle_cnt, byte_fifo.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/vlbp_pkg.sv
rtl/core/vlbp_pack.sv
rtl/core/variable_length_bit_packer.sv
test/tb_top.sv
